// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the I2C master byte engine RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Condition that must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/i2c_mbe_pkg.sv =====
// Types and constants of the I2C master byte engine.
// Used by the front end, the queue, the sequencer and the top level.
package i2c_mbe_pkg;

    // Input op codes.
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;

    // Classes assigned by the front end.
    localparam logic [1:0] CLS_NOP  = 2'd0;
    localparam logic [1:0] CLS_CMD  = 2'd1;
    localparam logic [1:0] CLS_TICK = 2'd2;

    // Command codes carried through the queue.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Sequencer state codes.
    localparam logic [2:0] KIND_IDLE  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    localparam logic [4:0] START_LAST_PHASE = 5'd1;
    localparam logic [4:0] STOP_LAST_PHASE  = 5'd2;
    localparam logic [4:0] BYTE_PHASES      = 5'd16;
    localparam logic [4:0] LAST_BYTE_PHASE  = 5'd17;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       nack;
    } t_out_item;

    typedef struct packed {
        logic [1:0] cls;
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_in;
    } t_q_item;

endpackage

// ===== rtl/core/i2c_master_byte_engine.sv =====
// I2C master byte engine: takes start, stop, write-byte and read-byte commands
// and tick transfers, and returns one result per input transfer with the SCL/SDA
// pin levels, SDA drive enable, busy/done status, last read byte and last write
// acknowledge. One input transfer is taken per clock while the queue is not full;
// each result passes through the input queue and the output result register, and
// the sequencer retires one queued transfer per cycle while the output does not
// stall. Each bus phase lasts phase_ticks tick transfers (0 counts as 1); write
// phase_ticks only while idle. Depends on i2c_mbe_pkg, i2c_mbe_front,
// i2c_mbe_fifo, i2c_mbe_back and assert_macros.svh.
`include "assert_macros.svh"
module i2c_master_byte_engine #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  i2c_mbe_pkg::t_in_item  i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output i2c_mbe_pkg::t_out_item o_out_item,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [7:0]             i_cfg_data
);
    import i2c_mbe_pkg::*;

    logic       r_phase_ticks;
    logic [7:0] r_ticks;
    logic       w_full;
    logic       w_empty;
    logic       w_push;
    logic       w_pop;
    t_q_item    w_push_item;
    t_q_item    w_head_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks       <= 8'd1;
            r_phase_ticks <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_ticks <= i_cfg_data;
            end
            r_phase_ticks <= i_cfg_valid;
        end
    end

    i2c_mbe_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_full   (w_full),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_q_item   (w_push_item)
    );

    i2c_mbe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_item  (w_head_item)
    );

    i2c_mbe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_phase_ticks (r_ticks),
        .i_q_empty     (w_empty),
        .i_q_item      (w_head_item),
        .o_pop         (w_pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_item    (o_out_item)
    );

    // User makes a configuration write only with the queue empty; not enforced.
    `ASSERT_CLK(a_cfg_idle, i_clk, i_rst_n, r_phase_ticks |-> $past(w_empty))

endmodule

// ===== rtl/core/i2c_mbe_front.sv =====
// Front end of the I2C master byte engine: accepts input transfers and
// classifies them into commands, ticks and ignored codes. Uses i2c_mbe_pkg.
module i2c_mbe_front (
    input  logic                  i_in_valid,
    input  i2c_mbe_pkg::t_in_item i_in_item,
    input  logic                  i_q_full,
    output logic                  o_in_stall,
    output logic                  o_push,
    output i2c_mbe_pkg::t_q_item  o_q_item
);
    import i2c_mbe_pkg::*;

    always_comb begin
        o_q_item.data_byte = i_in_item.data_byte;
        o_q_item.send_ack  = i_in_item.send_ack;
        o_q_item.sda_in    = i_in_item.sda_in;
        o_q_item.cmd       = i_in_item.op[1:0];
        case (i_in_item.op)
            OP_START, OP_STOP, OP_WRITE, OP_READ: o_q_item.cls = CLS_CMD;
            OP_TICK: o_q_item.cls = CLS_TICK;
            default: o_q_item.cls = CLS_NOP;
        endcase
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid & ~i_q_full;

endmodule

// ===== rtl/core/i2c_mbe_fifo.sv =====
// Short queue between the front end and the sequencer of the I2C engine.
// Uses i2c_mbe_pkg and assert_macros.svh.
`include "assert_macros.svh"
module i2c_mbe_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  i2c_mbe_pkg::t_q_item i_item,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output i2c_mbe_pkg::t_q_item o_item
);
    import i2c_mbe_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_q_item         r_slot [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr_ptr;
    logic [PW-1:0]   n_rd_ptr;
    logic [CW-1:0]   n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full)
    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && o_empty)
    `ASSERT_CLK(a_count_track, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))

endmodule

// ===== rtl/core/i2c_mbe_back.sv =====
// I2C master byte engine sequencer, using i2c_mbe_pkg: unless the output stalls,
// runs one queued transfer per cycle through phase logic; holds the result register.
`include "assert_macros.svh"
module i2c_mbe_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [7:0]             i_phase_ticks,
    input  logic                   i_q_empty,
    input  i2c_mbe_pkg::t_q_item   i_q_item,
    output logic                   o_pop,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output i2c_mbe_pkg::t_out_item o_out_item
);
    import i2c_mbe_pkg::*;

    logic [2:0] r_kind,  n_kind;
    logic [4:0] r_phase, n_phase;
    logic [7:0] r_tick,  n_tick;
    logic [7:0] r_shift, n_shift;
    logic       r_ackc,  n_ackc;
    logic       r_scl,   n_scl;
    logic       r_sda,   n_sda;
    logic       r_en,    n_en;
    logic       r_nack,  n_nack;
    logic [7:0] r_hold,  n_hold;
    logic       r_out_valid;
    t_out_item  r_out;

    logic       v_done;
    logic       v_enter;
    logic [4:0] v_ep;
    logic [7:0] v_limit;
    logic [7:0] v_tick;
    logic [4:0] v_last;

    assign o_pop = !i_q_empty && (!r_out_valid || !i_out_stall);

    always_comb begin
        case (r_kind)
            KIND_START: v_last = START_LAST_PHASE;
            KIND_STOP:  v_last = STOP_LAST_PHASE;
            default:    v_last = LAST_BYTE_PHASE;
        endcase
    end

    assign v_limit = (i_phase_ticks == '0) ? 8'd1 : i_phase_ticks;
    assign v_tick  = r_tick + 8'd1;

    always_comb begin
        n_kind  = r_kind;
        n_phase = r_phase;
        n_tick  = r_tick;
        n_shift = r_shift;
        n_ackc  = r_ackc;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_en    = r_en;
        n_nack  = r_nack;
        n_hold  = r_hold;
        v_done  = 1'b0;
        v_enter = 1'b0;
        v_ep    = '0;

        if (o_pop) begin
            if (i_q_item.cls == CLS_CMD && r_kind == KIND_IDLE) begin
                n_kind  = {1'b0, i_q_item.cmd} + 3'd1;
                n_phase = '0;
                n_tick  = '0;
                if (i_q_item.cmd == CMD_WRITE) begin
                    n_shift = i_q_item.data_byte;
                end
                if (i_q_item.cmd == CMD_READ) begin
                    n_shift = '0;
                    n_ackc  = i_q_item.send_ack;
                end
                v_enter = 1'b1;
            end else if (i_q_item.cls == CLS_TICK && r_kind != KIND_IDLE) begin
                if (v_tick >= v_limit) begin
                    n_tick = '0;
                    // Actions that close the current phase, including SDA samples.
                    case (r_kind)
                        KIND_START: begin
                            if (r_phase == 5'd1) n_scl = 1'b0;
                        end
                        KIND_WRITE: begin
                            if (r_phase < BYTE_PHASES) begin
                                if (r_phase[0]) n_scl = 1'b0;
                            end else if (r_phase == LAST_BYTE_PHASE) begin
                                n_nack = i_q_item.sda_in;
                                n_en   = 1'b1;
                                n_scl  = 1'b0;
                            end
                        end
                        KIND_READ: begin
                            if (r_phase < BYTE_PHASES) begin
                                if (!r_phase[0]) begin
                                    n_shift = {r_shift[6:0], i_q_item.sda_in};
                                    n_scl   = 1'b0;
                                end
                            end else if (r_phase == BYTE_PHASES) begin
                                n_scl = 1'b0;
                            end else begin
                                n_sda  = 1'b1;
                                n_hold = r_shift;
                            end
                        end
                        default: ;
                    endcase
                    if (r_phase >= v_last) begin
                        n_kind  = KIND_IDLE;
                        n_phase = '0;
                        v_done  = 1'b1;
                    end else begin
                        n_phase = r_phase + 5'd1;
                        v_enter = 1'b1;
                        v_ep    = r_phase + 5'd1;
                    end
                end else begin
                    n_tick = v_tick;
                end
            end
        end

        // Actions that open the phase being entered.
        if (v_enter) begin
            case (n_kind)
                KIND_START: begin
                    if (v_ep == 5'd1) n_sda = 1'b0;
                end
                KIND_STOP: begin
                    if (v_ep == 5'd0) n_sda = 1'b0;
                    else if (v_ep == 5'd1) n_scl = 1'b1;
                    else n_sda = 1'b1;
                end
                KIND_WRITE: begin
                    if (v_ep < BYTE_PHASES) begin
                        if (!v_ep[0]) n_sda = n_shift[3'd7 - v_ep[3:1]];
                        else n_scl = 1'b1;
                    end else if (v_ep == BYTE_PHASES) begin
                        n_en = 1'b0;
                    end else begin
                        n_scl = 1'b1;
                    end
                end
                KIND_READ: begin
                    if (v_ep < BYTE_PHASES) begin
                        if (!v_ep[0]) begin
                            if (v_ep == 5'd0) n_en = 1'b0;
                            n_scl = 1'b1;
                        end
                    end else if (v_ep == BYTE_PHASES) begin
                        n_en  = 1'b1;
                        n_sda = ~n_ackc;
                        n_scl = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= KIND_IDLE;
            r_phase     <= '0;
            r_tick      <= '0;
            r_shift     <= '0;
            r_ackc      <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_en        <= 1'b1;
            r_nack      <= 1'b0;
            r_hold      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_kind  <= n_kind;
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_shift <= n_shift;
            r_ackc  <= n_ackc;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_en    <= n_en;
            r_nack  <= n_nack;
            r_hold  <= n_hold;
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.scl_level <= n_scl;
            r_out.sda_level <= n_sda;
            r_out.sda_drive <= n_en;
            r_out.busy_res  <= (n_kind != KIND_IDLE);
            r_out.done_res  <= v_done;
            r_out.read_byte <= n_hold;
            r_out.nack      <= n_nack;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `ASSERT_NEVER(a_done_busy, i_clk, i_rst_n, r_out_valid && r_out.done_res && r_out.busy_res)
    `ASSERT_CLK(a_phase_range, i_clk, i_rst_n, r_phase <= LAST_BYTE_PHASE)
    `ASSERT_CLK(a_idle_clear, i_clk, i_rst_n, (r_kind == KIND_IDLE) |-> (r_phase == '0 && r_tick == '0))
    `ASSERT_CLK(a_pop_loads, i_clk, i_rst_n, o_pop |=> r_out_valid)

endmodule
